FILE: design/biou_pkg.sv
// Shared types for the box IoU core.
`default_nettype none
package biou_pkg;

  typedef struct packed {
    logic valid;
    logic empty;
    logic full;
  } biou_ctl_t;

endpackage
`default_nettype wire

FILE: design/box_iou_fixed_core.sv
// Top level of the box intersection-over-union core.
// Takes one box pair per clock (busy stays low) and returns overlap / union with
// RATIO_FRAC_BITS fraction bits, truncated. A pulse on done marks each result; the
// receiver cannot stall, so results leave in order. Between the start transfer and
// the result transfer lie the front registers for the overlap sides, area products,
// union and divisor set-up, a register per cell of the RATIO_FRAC_BITS-long
// restoring divider row, and the output register. A zero union gives ratio 0 with
// empty_union set.
`default_nettype none
module box_iou_fixed_core import biou_pkg::*; #(
  parameter int COORD_WIDTH     = 16,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] a_xmin,
  input  logic signed [COORD_WIDTH-1:0] a_ymin,
  input  logic signed [COORD_WIDTH-1:0] a_xmax,
  input  logic signed [COORD_WIDTH-1:0] a_ymax,
  input  logic signed [COORD_WIDTH-1:0] b_xmin,
  input  logic signed [COORD_WIDTH-1:0] b_ymin,
  input  logic signed [COORD_WIDTH-1:0] b_xmax,
  input  logic signed [COORD_WIDTH-1:0] b_ymax,
  output logic                          done,
  output logic [RATIO_FRAC_BITS:0]      overlap_ratio,
  output logic                          empty_union
);

  localparam int UW      = 2 * COORD_WIDTH + 1;
  localparam int R       = RATIO_FRAC_BITS;
  localparam int LATENCY = R + 5;

  biou_ctl_t        ctl_chain [0:R];
  logic [UW-1:0]    rem_chain [0:R];
  logic [UW-1:0]    div_chain [0:R];
  logic [R-1:0]     q_chain   [0:R];

  assign busy       = 1'b0;
  assign q_chain[0] = '0;

  biou_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .UNION_WIDTH (UW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .a_xmin   (a_xmin),
    .a_ymin   (a_ymin),
    .a_xmax   (a_xmax),
    .a_ymax   (a_ymax),
    .b_xmin   (b_xmin),
    .b_ymin   (b_ymin),
    .b_xmax   (b_xmax),
    .b_ymax   (b_ymax),
    .ctl      (ctl_chain[0]),
    .rem      (rem_chain[0]),
    .div      (div_chain[0])
  );

  for (genvar i = 0; i < R; i++) begin : g_cell
    biou_div_cell #(
      .UNION_WIDTH     (UW),
      .RATIO_FRAC_BITS (R)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_chain[i]),
      .rem_in  (rem_chain[i]),
      .div_in  (div_chain[i]),
      .q_in    (q_chain[i]),
      .ctl_out (ctl_chain[i+1]),
      .rem_out (rem_chain[i+1]),
      .div_out (div_chain[i+1]),
      .q_out   (q_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_chain[R].valid;
    end
    empty_union <= ctl_chain[R].empty;
    if (ctl_chain[R].empty) begin
      overlap_ratio <= '0;
    end else if (ctl_chain[R].full) begin
      overlap_ratio <= {1'b1, {R{1'b0}}};
    end else begin
      overlap_ratio <= {1'b0, q_chain[R]};
    end
  end

`ifndef SYNTHESIS
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("result transfer missing after start transfer");
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result transfer without matching start transfer");
  a_empty_gives_zero: assert property (@(posedge clk) disable iff (rst)
    done && empty_union |-> overlap_ratio == '0)
    else $error("empty union with nonzero ratio");
  a_ratio_bounded: assert property (@(posedge clk) disable iff (rst)
    done |-> overlap_ratio <= {1'b1, {R{1'b0}}})
    else $error("ratio above one");
`endif

endmodule
`default_nettype wire

FILE: design/biou_front.sv
// Overlap sides, box areas and union area ahead of the divider row.
`default_nettype none
module biou_front import biou_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int UNION_WIDTH = 2 * COORD_WIDTH + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] a_xmin,
  input  logic signed [COORD_WIDTH-1:0] a_ymin,
  input  logic signed [COORD_WIDTH-1:0] a_xmax,
  input  logic signed [COORD_WIDTH-1:0] a_ymax,
  input  logic signed [COORD_WIDTH-1:0] b_xmin,
  input  logic signed [COORD_WIDTH-1:0] b_ymin,
  input  logic signed [COORD_WIDTH-1:0] b_xmax,
  input  logic signed [COORD_WIDTH-1:0] b_ymax,
  output biou_ctl_t                     ctl,
  output logic [UNION_WIDTH-1:0]        rem,
  output logic [UNION_WIDTH-1:0]        div
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = UNION_WIDTH - 1;

  function automatic logic [W-1:0] side(input logic signed [W-1:0] lo,
                                        input logic signed [W-1:0] hi);
    logic [W:0] d;
    d = {hi[W-1], hi} - {lo[W-1], lo};
    side = d[W] ? '0 : d[W-1:0];
  endfunction

  logic signed [W-1:0] ox0, oy0, ox1, oy1;

  logic         s1_valid;
  logic [W-1:0] s1_ow, s1_oh, s1_aw, s1_ah, s1_bw, s1_bh;
  logic          s2_valid;
  logic [PW-1:0] s2_ov, s2_a1, s2_a2;
  logic                   s3_valid;
  logic [PW-1:0]          s3_ov;
  logic [UNION_WIDTH-1:0] s3_uni;

  always_comb begin
    ox0 = (a_xmin > b_xmin) ? a_xmin : b_xmin;
    oy0 = (a_ymin > b_ymin) ? a_ymin : b_ymin;
    ox1 = (a_xmax < b_xmax) ? a_xmax : b_xmax;
    oy1 = (a_ymax < b_ymax) ? a_ymax : b_ymax;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      ctl.valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      ctl.valid <= s3_valid;
    end
    s1_ow <= side(ox0, ox1);
    s1_oh <= side(oy0, oy1);
    s1_aw <= side(a_xmin, a_xmax);
    s1_ah <= side(a_ymin, a_ymax);
    s1_bw <= side(b_xmin, b_xmax);
    s1_bh <= side(b_ymin, b_ymax);
    s2_ov <= {{W{1'b0}}, s1_ow} * {{W{1'b0}}, s1_oh};
    s2_a1 <= {{W{1'b0}}, s1_aw} * {{W{1'b0}}, s1_ah};
    s2_a2 <= {{W{1'b0}}, s1_bw} * {{W{1'b0}}, s1_bh};
    s3_ov  <= s2_ov;
    s3_uni <= {1'b0, s2_a1} + {1'b0, s2_a2} - {1'b0, s2_ov};
    ctl.empty <= (s3_uni == '0);
    ctl.full  <= (s3_uni == {1'b0, s3_ov});
    rem <= {1'b0, s3_ov};
    div <= s3_uni;
  end

`ifndef SYNTHESIS
  a_union_covers_overlap: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> s3_uni >= {1'b0, s3_ov})
    else $error("union area below overlap area");
`endif

endmodule
`default_nettype wire

FILE: design/biou_div_cell.sv
// One restoring division step: one quotient bit per cell.
`default_nettype none
module biou_div_cell import biou_pkg::*; #(
  parameter int UNION_WIDTH     = 33,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  biou_ctl_t                  ctl_in,
  input  logic [UNION_WIDTH-1:0]     rem_in,
  input  logic [UNION_WIDTH-1:0]     div_in,
  input  logic [RATIO_FRAC_BITS-1:0] q_in,
  output biou_ctl_t                  ctl_out,
  output logic [UNION_WIDTH-1:0]     rem_out,
  output logic [UNION_WIDTH-1:0]     div_out,
  output logic [RATIO_FRAC_BITS-1:0] q_out
);

  localparam int UW = UNION_WIDTH;

  logic [UW:0] shifted;
  logic [UW:0] diff;
  logic        fit;

  always_comb begin
    shifted = {rem_in, 1'b0};
    diff    = shifted - {1'b0, div_in};
    fit     = !diff[UW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    rem_out <= fit ? diff[UW-1:0] : shifted[UW-1:0];
    div_out <= div_in;
    q_out   <= {q_in[RATIO_FRAC_BITS-2:0], fit};
  end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for box_iou_fixed_core: box-pair stimulus and ratio scoreboard.
`timescale 1ns / 1ps
module testbench;
  localparam int COORD_W     = 16;
  localparam int RATIO_FB    = 16;
  localparam int PAIR_COUNT  = 1100;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [COORD_W-1:0] SIGN_BIT = {1'b1, {(COORD_W - 1){1'b0}}};
  localparam logic [RATIO_FB:0] RATIO_ONE = {1'b1, {RATIO_FB{1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] xmin;
    logic signed [COORD_W-1:0] ymin;
    logic signed [COORD_W-1:0] xmax;
    logic signed [COORD_W-1:0] ymax;
  } box_t;

  typedef struct packed {
    logic [RATIO_FB:0] ratio;
    logic              empty;
  } iou_t;

  class iou_scoreboard;
    iou_t iou_q[$];
    int   errors;
    int   pairs;
    int   results;
    int   empties;
    int   unity;

    // coordinates in offset binary, so unsigned compares follow signed order
    function logic [63:0] box_area(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                                   logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1);
      logic [63:0] w;
      logic [63:0] h;
      if (x1 < x0 || y1 < y0) return 64'd0;
      w = 64'(x1 - x0);
      h = 64'(y1 - y0);
      return w * h;
    endfunction

    function void note_pair(box_t a, box_t b);
      logic [COORD_W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      logic [63:0] ov, a1, a2, un, q;
      iou_t r;
      ax0 = a.xmin ^ SIGN_BIT;
      ay0 = a.ymin ^ SIGN_BIT;
      ax1 = a.xmax ^ SIGN_BIT;
      ay1 = a.ymax ^ SIGN_BIT;
      bx0 = b.xmin ^ SIGN_BIT;
      by0 = b.ymin ^ SIGN_BIT;
      bx1 = b.xmax ^ SIGN_BIT;
      by1 = b.ymax ^ SIGN_BIT;
      ov = box_area((ax0 > bx0) ? ax0 : bx0, (ay0 > by0) ? ay0 : by0,
                    (ax1 < bx1) ? ax1 : bx1, (ay1 < by1) ? ay1 : by1);
      a1 = box_area(ax0, ay0, ax1, ay1);
      a2 = box_area(bx0, by0, bx1, by1);
      un = a1 + a2 - ov;
      r.empty = (un == 64'd0);
      q = r.empty ? 64'd0 : ((ov << RATIO_FB) / un);
      r.ratio = q[RATIO_FB:0];
      iou_q.push_back(r);
      pairs++;
      if (r.empty) empties++;
      if (r.ratio == RATIO_ONE) unity++;
    endfunction

    function void check_result(logic [RATIO_FB:0] ratio, logic empty);
      iou_t want;
      results++;
      if (iou_q.size() == 0) begin
        errors++;
        $display("%0t: result ratio=%0d empty_union=%0b with no box pair outstanding",
                 $time, ratio, empty);
        return;
      end
      want = iou_q.pop_front();
      if (ratio !== want.ratio) begin
        errors++;
        $display("%0t: overlap_ratio expected %0d, actual %0d", $time, want.ratio, ratio);
      end
      if (empty !== want.empty) begin
        errors++;
        $display("%0t: empty_union expected %0b, actual %0b", $time, want.empty, empty);
      end
    endfunction

    function int pending();
      return iou_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] a_xmin = '0, a_ymin = '0, a_xmax = '0, a_ymax = '0;
  logic signed [COORD_W-1:0] b_xmin = '0, b_ymin = '0, b_xmax = '0, b_ymax = '0;
  logic done;
  logic [RATIO_FB:0] overlap_ratio;
  logic empty_union;
  int cycle_count = 0;

  iou_scoreboard sb = new;

  always #5 clk = ~clk;

  box_iou_fixed_core #(
    .COORD_WIDTH(COORD_W),
    .RATIO_FRAC_BITS(RATIO_FB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .a_xmin(a_xmin),
    .a_ymin(a_ymin),
    .a_xmax(a_xmax),
    .a_ymax(a_ymax),
    .b_xmin(b_xmin),
    .b_ymin(b_ymin),
    .b_xmax(b_xmax),
    .b_ymax(b_ymax),
    .done(done),
    .overlap_ratio(overlap_ratio),
    .empty_union(empty_union)
  );

  always @(posedge clk) begin
    if (!rst && start && !busy)
      sb.note_pair({a_xmin, a_ymin, a_xmax, a_ymax}, {b_xmin, b_ymin, b_xmax, b_ymax});
    if (!rst && done)
      sb.check_result(overlap_ratio, empty_union);
  end

  function automatic int clamp(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic box_t mk(int x0, int y0, int x1, int y1);
    box_t r;
    r.xmin = COORD_W'(x0);
    r.ymin = COORD_W'(y0);
    r.xmax = COORD_W'(x1);
    r.ymax = COORD_W'(y1);
    return r;
  endfunction

  function automatic box_t rand_raw();
    return mk($urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
  endfunction

  function automatic box_t rand_box(int span);
    int x0;
    int y0;
    x0 = int'($urandom_range(0, 65535)) - 32768;
    y0 = int'($urandom_range(0, 65535)) - 32768;
    return mk(x0, y0, clamp(x0 + int'($urandom_range(0, span))),
              clamp(y0 + int'($urandom_range(0, span))));
  endfunction

  function automatic int rand_off(int d);
    return int'($urandom_range(0, 2 * d)) - d;
  endfunction

  // neighbor of a box; edges may cross, which gives inverted boxes now and then
  function automatic box_t jitter(box_t a, int d);
    return mk(clamp(a.xmin + rand_off(d)), clamp(a.ymin + rand_off(d)),
              clamp(a.xmax + rand_off(d)), clamp(a.ymax + rand_off(d)));
  endfunction

  task automatic drive_pair(input box_t a, input box_t b);
    start  <= 1'b1;
    a_xmin <= a.xmin;
    a_ymin <= a.ymin;
    a_xmax <= a.xmax;
    a_ymax <= a.ymax;
    b_xmin <= b.xmin;
    b_ymin <= b.ymin;
    b_xmax <= b.xmax;
    b_ymax <= b.ymax;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    drive_pair(mk(0, 0, 160, 160), mk(0, 0, 160, 160));
    drive_pair(mk(-32768, -32768, 32767, 32767), mk(-32768, -32768, 32767, 32767));
    drive_pair(mk(-32768, -32768, 32767, 32767), mk(0, 0, 16, 16));
    drive_pair(mk(-32768, -32768, 32767, 32767), mk(-32768, -32768, 32767, 32766));
    drive_pair(mk(0, 0, 16, 16), mk(32, 32, 64, 64));
    drive_pair(mk(0, 0, 16, 16), mk(16, 0, 32, 16));
    drive_pair(mk(5, 5, 5, 5), mk(7, 7, 7, 7));
    drive_pair(mk(100, 100, -100, -100), mk(50, 50, -50, -50));
    idle(2);
    drive_pair(mk(100, 100, -100, -100), mk(0, 0, 32, 32));
    drive_pair(mk(0, 0, 32, 32), mk(10, 40, 20, -40));
    drive_pair(mk(0, 0, 0, 64), mk(0, 0, 64, 0));
    drive_pair(mk(0, 0, 0, 64), mk(-8, -8, 8, 8));
    drive_pair(mk(-64, -64, 64, 64), mk(-16, -16, 16, 16));
    drive_pair(mk(0, 0, 48, 48), mk(16, 16, 64, 64));
    drive_pair(mk(0, 0, 3, 3), mk(1, 1, 4, 4));
    idle(1);
    drive_pair(mk(32767, 32767, 32767, 32767), mk(-32768, -32768, -32768, -32768));
    drive_pair(mk(-32768, -32768, -32767, -32767), mk(32766, 32766, 32767, 32767));
    drive_pair(mk(-1, -1, 1, 1), mk(-1, -1, 1, 1));
    drive_pair(mk(32767, 32767, -32768, -32768), mk(-32768, -32768, 32767, 32767));
    drive_pair(mk(21845, -21846, 21845, 21845), mk(-21846, -21846, 21845, 21845));
    idle(3);
  endtask

  task automatic run_random();
    int left;
    int burst;
    int mode;
    box_t a;
    box_t b;
    left = PAIR_COUNT;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && left > 0; i++) begin
        mode = $urandom_range(0, 9);
        case (mode)
          0, 1: begin
            a = rand_raw();
            b = rand_raw();
          end
          7: begin
            a = rand_box(4096);
            b = jitter(a, 2048);
          end
          8: begin
            a = rand_box(64);
            b = a;
          end
          9: begin
            a = rand_box(65535);
            b = rand_box(65535);
          end
          default: begin
            a = rand_box(64);
            b = jitter(a, 32);
          end
        endcase
        if ($urandom_range(0, 1) == 1) drive_pair(a, b);
        else drive_pair(b, a);
        left--;
      end
      idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (RATIO_FB + 10) @(posedge clk);
    $display("%0d box pairs transferred, %0d results checked in %0d cycles",
             sb.pairs, sb.results, cycle_count);
    $display("%0d empty unions, %0d exact 1.0 ratios, %0d mismatches",
             sb.empties, sb.unity, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: box_iou_fixed_core.f
design/biou_pkg.sv
design/biou_front.sv
design/biou_div_cell.sv
design/box_iou_fixed_core.sv
tb/testbench.sv
